// ----- rtl/dj_pkg.sv -----
// Shared types, constants and table functions for the de Jong point generator.
// Used by the point channel interface, the coefficient registers, the sine term and the top level.
`default_nettype none

package dj_pkg;

	localparam int COEF_W   = 16;
	localparam int STATE_W  = 16;
	localparam int POINT_W  = 15;
	localparam int TURN_K_W = 30;
	localparam int SCALED_W = COEF_W + TURN_K_W;

	// 2^32 / (2*pi), rounded: turns one radian product into a 32-bit fraction of a turn.
	localparam logic [TURN_K_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;

	// 2*pi and 1.0 in Q30.
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SCALED_W-1:0] scaled_coef_t;
	typedef logic signed [STATE_W-1:0]  state_t;
	typedef logic signed [POINT_W-1:0]  point_t;

	typedef enum logic [1:0] {
		CFG_COEF_A = 2'd0,
		CFG_COEF_B = 2'd1,
		CFG_COEF_C = 2'd2,
		CFG_COEF_D = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		scaled_coef_t a;
		scaled_coef_t b;
		scaled_coef_t c;
		scaled_coef_t d;
	} scaled_coefs_t;

	localparam coef_t COEF_A_RESET = -16'sd6963;
	localparam coef_t COEF_B_RESET = 16'sd5325;
	localparam coef_t COEF_C_RESET = -16'sd4096;
	localparam coef_t COEF_D_RESET = -16'sd819;

	// Coefficient premultiplied by the turn constant, so the per-point path has one multiply.
	function automatic scaled_coef_t scale_coef(coef_t c);
		scaled_coef_t r;
		r = SCALED_W'(c) * $signed({1'b0, INV_TWO_PI_Q32});
		return r;
	endfunction

	// Sine magnitude of a Q30 angle in [0, pi/2], rounded to frac_bits fraction bits.
	function automatic logic [63:0] sine_mag(logic [63:0] ax, int frac_bits);
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] m;
		x2 = (ax * ax) >> 30;
		h  = ONE_Q30;
		h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd156;
		h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd110;
		h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
		h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
		h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
		h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
		m  = (ax * h) >> 30;
		return (m + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
	endfunction

	// Quarter-wave entry j: the low word is the sine for the first quadrant, the high word
	// the value used when the angle is folded back from the second quadrant. They differ
	// only where the angle sits exactly halfway between two Q30 steps, because the fold
	// then lands one step lower.
	function automatic logic [63:0] quarter_entry(int j, int lg_n, int frac_bits);
		logic [63:0] num;
		logic [63:0] x;
		logic [63:0] xt;
		logic        tie;
		num = 64'(j) * TWO_PI_Q30;
		x   = (num + (64'd1 << (lg_n - 1))) >> lg_n;
		tie = (num & ((64'd1 << lg_n) - 64'd1)) == (64'd1 << (lg_n - 1));
		xt  = tie ? x - 64'd1 : x;
		return (sine_mag(xt, frac_bits) << 32) | sine_mag(x, frac_bits);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dj_tick_if.sv -----
// Request channel into the point generator: one step per request, with the restart flag.
// Depends on nothing but plain logic types.
`default_nettype none

interface dj_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ----- rtl/dj_point_if.sv -----
// Result channel out of the point generator: one point per request.
// Depends on dj_pkg for the point type.
`default_nettype none

interface dj_point_if;
	logic           valid;
	logic           ready;
	dj_pkg::point_t point_x;
	dj_pkg::point_t point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/dj_coef_regs.sv -----
// Coefficient registers of the point generator, held premultiplied by 2^32/(2*pi).
// Depends on dj_pkg.
`default_nettype none

module dj_coef_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  dj_pkg::cfg_idx_t      cfg_index,
	input  dj_pkg::coef_t         cfg_data,
	output dj_pkg::scaled_coefs_t coefs
);
	import dj_pkg::*;

	scaled_coef_t  wr_scaled;
	scaled_coefs_t coefs_q;

	assign wr_scaled = scale_coef(cfg_data);
	assign coefs     = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.a <= scale_coef(COEF_A_RESET);
			coefs_q.b <= scale_coef(COEF_B_RESET);
			coefs_q.c <= scale_coef(COEF_C_RESET);
			coefs_q.d <= scale_coef(COEF_D_RESET);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_COEF_A: coefs_q.a <= wr_scaled;
				CFG_COEF_B: coefs_q.b <= wr_scaled;
				CFG_COEF_C: coefs_q.c <= wr_scaled;
				CFG_COEF_D: coefs_q.d <= wr_scaled;
				default:    coefs_q   <= coefs_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dj_sine_term.sv -----
// One sine or cosine term: coefficient times coordinate, angle reduction, quarter-wave lookup.
// Depends on dj_pkg for types and the table functions.
`default_nettype none

module dj_sine_term #(
	parameter int SINE_TABLE_ENTRIES = 1024,
	parameter int FRAC_BITS          = 12
) (
	input  dj_pkg::scaled_coef_t         coef_k,
	input  dj_pkg::state_t               operand,
	input  logic                         quarter,
	output logic signed [FRAC_BITS+1:0]  value
);
	import dj_pkg::*;

	localparam int LG_N      = $clog2(SINE_TABLE_ENTRIES);
	localparam int PROD_W    = SCALED_W + STATE_W;
	localparam int TURN_LSB  = 2 * FRAC_BITS;
	localparam int TURN_MSB  = TURN_LSB + 31;
	localparam int EXT_W     = (TURN_MSB + 1 > PROD_W) ? TURN_MSB + 1 : PROD_W;
	localparam int QTR_DEPTH = SINE_TABLE_ENTRIES / 4 + 1;
	localparam int QIDX_W    = LG_N - 1;
	localparam int MAG_W     = FRAC_BITS + 1;
	localparam logic [LG_N-1:0] QTR_N  = LG_N'(SINE_TABLE_ENTRIES / 4);
	localparam logic [LG_N-1:0] HALF_N = LG_N'(SINE_TABLE_ENTRIES / 2);

	logic signed [PROD_W-1:0] prod;
	logic signed [EXT_W-1:0]  prod_ext;
	logic [LG_N:0]            turn_top;
	logic [LG_N-1:0]          idx_sin;
	logic [LG_N-1:0]          idx;
	logic                     half;
	logic [LG_N-1:0]          r;
	logic [LG_N-1:0]          rc;
	logic                     sel_main;
	logic [QIDX_W-1:0]        addr;
	logic [2*MAG_W-1:0]       qtab [QTR_DEPTH];
	logic [2*MAG_W-1:0]       entry;
	logic [MAG_W-1:0]         mag;

	// Bits of the product past the fraction bits form the angle as a fraction of a turn;
	// the bits above the turn fall away, which is the reduction modulo 2*pi.
	assign prod     = coef_k * operand;
	assign prod_ext = EXT_W'(prod);
	assign turn_top = prod_ext[TURN_MSB -: LG_N+1];

	// Round to the nearest table step; a cosine is the sine a quarter turn further on.
	assign idx_sin = turn_top[LG_N:1] + LG_N'(turn_top[0]);
	assign idx     = idx_sin + (quarter ? QTR_N : '0);

	// Fold the full turn onto the quarter table: the second half is the negated first half,
	// and the second quadrant reads the mirrored entry through its tie column.
	assign half     = idx[LG_N-1];
	assign r        = {1'b0, idx[LG_N-2:0]};
	assign rc       = HALF_N - r;
	assign sel_main = half ? (r >= QTR_N) : (r <= QTR_N);
	assign addr     = (half == sel_main) ? rc[QIDX_W-1:0] : r[QIDX_W-1:0];

	for (genvar j = 0; j < QTR_DEPTH; j++) begin : g_qtab
		localparam logic [63:0] ENT = quarter_entry(j, LG_N, FRAC_BITS);
		assign qtab[j] = {ENT[32 +: MAG_W], ENT[0 +: MAG_W]};
	end

	assign entry = qtab[addr];
	assign mag   = sel_main ? entry[MAG_W-1:0] : entry[2*MAG_W-1:MAG_W];
	assign value = half ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

`default_nettype wire

// ----- rtl/de_jong_attractor_point_generator.sv -----
// Top level of the de Jong attractor point generator: input stage, point state, result stage.
// Depends on dj_pkg, dj_tick_if, dj_point_if, dj_coef_regs and dj_sine_term.
//
//   channel   kind            signals
//   tick      request in      valid, ready, restart
//   point     request out     valid, ready, point_x, point_y
//   cfg       write port      cfg_wen, cfg_index, cfg_data
//
// One point per clock while the receiver keeps up; a taken request waits in the input stage,
// then its point is registered in the result stage and offered. The stored point, the
// coefficient multiply, the quarter-wave table and the subtract form a loop that sets that rate.
// Reset puts the coefficients at their defaults and the point at the origin; no clearing pass.
// A stalled result holds in the output stage while one more request waits in the input stage.
`default_nettype none

module de_jong_attractor_point_generator #(
	parameter int SINE_TABLE_ENTRIES = 1024,
	parameter int FRAC_BITS          = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	dj_tick_if.sink          tick,
	dj_point_if.source       point,
	input  logic             cfg_wen,
	input  dj_pkg::cfg_idx_t cfg_index,
	input  dj_pkg::coef_t    cfg_data
);
	import dj_pkg::*;

	localparam int TERM_W = FRAC_BITS + 2;
	localparam int DIFF_W = FRAC_BITS + 3;

	scaled_coefs_t            coefs;
	logic                     v_s1;
	logic                     restart_s1;
	logic                     v_s2;
	point_t                   px_s2;
	point_t                   py_s2;
	state_t                   prev_x_q;
	state_t                   prev_y_q;
	state_t                   op_x;
	state_t                   op_y;
	logic                     out_free;
	logic                     advance;
	logic signed [TERM_W-1:0] sin_a;
	logic signed [TERM_W-1:0] cos_b;
	logic signed [TERM_W-1:0] sin_c;
	logic signed [TERM_W-1:0] cos_d;
	logic signed [DIFF_W-1:0] nx;
	logic signed [DIFF_W-1:0] ny;

	dj_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	assign out_free   = !v_s2 || point.ready;
	assign advance    = v_s1 && out_free;
	assign tick.ready = !v_s1 || out_free;

	assign op_x = restart_s1 ? '0 : prev_x_q;
	assign op_y = restart_s1 ? '0 : prev_y_q;

	dj_sine_term #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_sin_a (
		.coef_k (coefs.a), .operand (op_y), .quarter (1'b0), .value (sin_a)
	);
	dj_sine_term #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_cos_b (
		.coef_k (coefs.b), .operand (op_x), .quarter (1'b1), .value (cos_b)
	);
	dj_sine_term #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_sin_c (
		.coef_k (coefs.c), .operand (op_x), .quarter (1'b0), .value (sin_c)
	);
	dj_sine_term #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_cos_d (
		.coef_k (coefs.d), .operand (op_y), .quarter (1'b1), .value (cos_d)
	);

	assign nx = DIFF_W'(sin_a) - DIFF_W'(cos_b);
	assign ny = DIFF_W'(sin_c) - DIFF_W'(cos_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			if (tick.ready) begin
				v_s1 <= tick.valid;
			end
			if (out_free) begin
				v_s2 <= v_s1;
			end
			if (advance) begin
				prev_x_q <= STATE_W'(nx);
				prev_y_q <= STATE_W'(ny);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			restart_s1 <= tick.restart;
		end
		if (advance) begin
			px_s2 <= POINT_W'(nx);
			py_s2 <= POINT_W'(ny);
		end
	end

	assign point.valid   = v_s2;
	assign point.point_x = px_s2;
	assign point.point_y = py_s2;

	// A request leaving the input stage always shows up as a result.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> point.valid)
		else $error("advanced request did not reach the output stage");

	// The stored point moves only with a request that completes its step.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(prev_x_q) && $stable(prev_y_q))
		else $error("stored point changed without a completed step");

	// A request blocked behind a stalled result keeps its place and its flag.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !out_free) |=> v_s1 && $stable(restart_s1))
		else $error("blocked request lost from the input stage");

endmodule

`default_nettype wire

// ----- verif/de_jong_attractor_point_generator_tb.sv -----
// Self-checking testbench for the de Jong attractor point generator.
// It drives the step and point channels and the coefficient write port, and predicts each point.
// Depends on dj_pkg, dj_tick_if, dj_point_if and the de_jong_attractor_point_generator top level.
`default_nettype none

module de_jong_attractor_point_generator_tb;
	import dj_pkg::*;

	localparam int SINE_ENTRIES   = 1024;
	localparam int FRAC           = 12;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 64;
	localparam int SEGMENT_ITEMS  = 100;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint TURN_SCALE  = 64'sd683565276;

	localparam coef_t  C_MIN  = 16'sh8000;
	localparam coef_t  C_MAX  = 16'sh7FFF;
	localparam coef_t  C_ZERO = 16'sh0000;
	// From the origin, or with all coefficients zero, both sines are 0 and both cosines 1.0.
	localparam point_t ORIGIN_STEP = -15'sd4096;

	typedef struct packed {
		point_t x;
		point_t y;
	} point_pair_t;

	typedef struct packed {
		logic   load;
		coef_t  a;
		coef_t  b;
		coef_t  c;
		coef_t  d;
		logic   rs;
		logic   known;
		point_t ex;
		point_t ey;
	} dir_row_t;

	localparam int DIR_N = 20;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wen;
	cfg_idx_t         cfg_index;
	coef_t            cfg_data;

	dj_tick_if  tick ();
	dj_point_if point ();

	de_jong_attractor_point_generator #(
		.SINE_TABLE_ENTRIES(SINE_ENTRIES),
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.point(point),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	int          sine_rom [SINE_ENTRIES];
	coef_t       coefs [4];
	state_t      orbit_x;
	state_t      orbit_y;
	point_pair_t pending_points [$];
	dir_row_t    dir_rows [DIR_N];

	int   src_idle_pct;
	int   snk_idle_pct;
	logic hold_pending;
	int   hold_left;
	int   quiet_cycles;
	int   mismatches;
	int   points_seen;
	int   items_sent;
	int   restarts_sent;
	int   coef_writes;

	always #10 clk = ~clk;

	// Table entry k holds the sine of 2*pi*k/N, with the angle folded into [-pi/2, pi/2].
	function automatic int sine_rom_entry(int k);
		longint            kk;
		longint            num;
		longint            x;
		longint unsigned   mag;
		longint unsigned   ax;
		longint unsigned   x2;
		longint unsigned   h;
		longint unsigned   m;
		longint unsigned   r;
		longint unsigned   dv;
		kk  = (2 * k >= SINE_ENTRIES) ? longint'(k - SINE_ENTRIES) : longint'(k);
		num = kk * PI_Q30 * 2;
		mag = (num < 0) ? -num : num;
		x   = (mag + SINE_ENTRIES / 2) / SINE_ENTRIES;
		if (num < 0)
			x = -x;
		if (x > HALF_PI_Q30)
			x = PI_Q30 - x;
		if (x < -HALF_PI_Q30)
			x = -PI_Q30 - x;
		ax = (x < 0) ? -x : x;
		x2 = (ax * ax) >> 30;
		h  = 64'd1 << 30;
		for (int i = 0; i < 6; i++) begin
			case (i)
				0: dv = 156;
				1: dv = 110;
				2: dv = 72;
				3: dv = 42;
				4: dv = 20;
				default: dv = 6;
			endcase
			h = (64'd1 << 30) - ((x2 * h) >> 30) / dv;
		end
		m = (ax * h) >> 30;
		r = (m + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		return (x < 0) ? -int'(r) : int'(r);
	endfunction

	// The angle coef*val as a 32-bit fraction of a turn, floored modulo one turn.
	function automatic logic [31:0] turn_of(coef_t c, state_t v);
		longint q;
		q = longint'(c) * longint'(v) * TURN_SCALE;
		q = q >>> (2 * FRAC);
		return q[31:0];
	endfunction

	function automatic int rom_at_turn(logic [31:0] t);
		logic [63:0] idx;
		idx = (64'(t) * 64'(SINE_ENTRIES) + (64'd1 << 31)) >> 32;
		if (idx >= SINE_ENTRIES)
			idx = 0;
		return sine_rom[idx];
	endfunction

	function automatic point_pair_t next_attractor_point(logic rs);
		int          nx;
		int          ny;
		point_pair_t res;
		if (rs) begin
			orbit_x = '0;
			orbit_y = '0;
		end
		nx = rom_at_turn(turn_of(coefs[CFG_COEF_A], orbit_y))
			- rom_at_turn(turn_of(coefs[CFG_COEF_B], orbit_x) + 32'h4000_0000);
		ny = rom_at_turn(turn_of(coefs[CFG_COEF_C], orbit_x))
			- rom_at_turn(turn_of(coefs[CFG_COEF_D], orbit_y) + 32'h4000_0000);
		orbit_x = nx[STATE_W-1:0];
		orbit_y = ny[STATE_W-1:0];
		res.x = nx[POINT_W-1:0];
		res.y = ny[POINT_W-1:0];
		return res;
	endfunction

	function automatic coef_t random_coef();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return C_MIN;
			1: return C_MAX;
			2: return C_ZERO;
			default: return r[COEF_W-1:0];
		endcase
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_tick(logic rs, logic known, point_t ex, point_t ey);
		point_pair_t p;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			tick.valid <= 1'b0;
			@(negedge clk);
		end
		tick.valid   <= 1'b1;
		tick.restart <= rs;
		do @(posedge clk); while (!tick.ready);
		p = next_attractor_point(rs);
		if (known) begin
			p.x = ex;
			p.y = ey;
		end
		pending_points.push_back(p);
		items_sent++;
		if (rs)
			restarts_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		tick.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_coefs(coef_t a, coef_t b, coef_t c, coef_t d);
		cfg_idx_t order [4];
		coef_t    vals [4];
		order = '{CFG_COEF_A, CFG_COEF_B, CFG_COEF_C, CFG_COEF_D};
		vals  = '{a, b, c, d};
		for (int i = 0; i < 4; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			coefs[order[i]] = vals[i];
			coef_writes++;
			@(negedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off on request from the stimulus.
	always @(negedge clk) begin
		if (hold_pending) begin
			hold_left    = HOLD_CYCLES;
			hold_pending = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			point.ready <= 1'b0;
		end else begin
			point.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		point_pair_t exp_pt;
		if (arst_n && point.valid && point.ready) begin
			points_seen++;
			if (pending_points.size() == 0) begin
				$error("unexpected point: x=%0d y=%0d", point.point_x, point.point_y);
				mismatches++;
			end else begin
				exp_pt = pending_points.pop_front();
				if (point.point_x !== exp_pt.x) begin
					$error("point_x: expected %0d, got %0d", exp_pt.x, point.point_x);
					mismatches++;
				end
				if (point.point_y !== exp_pt.y) begin
					$error("point_y: expected %0d, got %0d", exp_pt.y, point.point_y);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((tick.valid && tick.ready) || (point.valid && point.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		tick.valid   = 1'b0;
		tick.restart = 1'b0;
		point.ready  = 1'b0;
		cfg_wen      = 1'b0;
		cfg_index    = CFG_COEF_A;
		cfg_data     = '0;
		hold_pending = 1'b0;
		hold_left    = 0;
		quiet_cycles = 0;
		mismatches   = 0;
		points_seen  = 0;
		items_sent   = 0;
		restarts_sent = 0;
		coef_writes  = 0;
		src_idle_pct = 18;
		snk_idle_pct = 67;

		for (int k = 0; k < SINE_ENTRIES; k++)
			sine_rom[k] = sine_rom_entry(k);
		coefs[CFG_COEF_A] = COEF_A_RESET;
		coefs[CFG_COEF_B] = COEF_B_RESET;
		coefs[CFG_COEF_C] = COEF_C_RESET;
		coefs[CFG_COEF_D] = COEF_D_RESET;
		orbit_x = '0;
		orbit_y = '0;

		// load, a, b, c, d, restart, known, x, y
		dir_rows = '{
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b1, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b1, C_MAX,  C_MAX,  C_MAX,  C_MAX,  1'b1, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b1, C_MIN,  C_MIN,  C_MIN,  C_MIN,  1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b1, C_MAX,  C_MIN,  C_MIN,  C_MAX,  1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0},
			'{1'b1, COEF_A_RESET, COEF_B_RESET, COEF_C_RESET, COEF_D_RESET,
				1'b1, 1'b1, ORIGIN_STEP, ORIGIN_STEP},
			'{1'b0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, '0, '0}
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (dir_rows[i].load) begin
				wait_idle();
				set_coefs(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].d);
			end
			send_tick(dir_rows[i].rs, dir_rows[i].known, dir_rows[i].ex, dir_rows[i].ey);
		end

		// Long orbits with random coefficients; restarts are occasional.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					src_idle_pct = 18;
					snk_idle_pct = 67;
				end
				1: begin
					src_idle_pct = 67;
					snk_idle_pct = 18;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				wait_idle();
				set_coefs(random_coef(), random_coef(), random_coef(), random_coef());
				// With nothing idling, a long receiver hold-off lets the block fill and stall.
				if (mode == 2 && seg == 0)
					hold_pending = 1'b1;
				for (int n = 0; n < SEGMENT_ITEMS; n++)
					send_tick($urandom_range(0, 24) == 0, 1'b0, '0, '0);
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);

		$display("Covered %0d requests (%0d restarts) and %0d coefficient writes,",
			items_sent, restarts_sent, coef_writes);
		$display("with sender and receiver stalls swapped, none, and one long hold-off.");
		if (mismatches == 0 && pending_points.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
